// File: rtl/core/scsu_pkg.sv
// Shared types, constants and window tables for the SCSU decoder.
// No dependencies; imported by the decode logic and the top level.
`timescale 1ns / 1ps
`default_nettype none

package scsu_pkg;

   localparam int BASE_W = 21;

   typedef logic [BASE_W-1:0] base_type;
   typedef logic [7:0][BASE_W-1:0] win_arr_type;

   typedef enum logic [2:0] {
      PH_NONE = 3'd0,
      PH_SQN  = 3'd1,
      PH_QHI  = 3'd2,
      PH_QLO  = 3'd3,
      PH_DOFF = 3'd4,
      PH_DXHI = 3'd5,
      PH_DXLO = 3'd6
   } phase_type;

   localparam logic [1:0] ST_UNIT  = 2'd0;
   localparam logic [1:0] ST_ERR   = 2'd1;
   localparam logic [1:0] ST_TRUNC = 2'd2;

   // single-byte mode tags
   localparam logic [7:0] TAG_SQ0 = 8'h01;
   localparam logic [7:0] TAG_SQ7 = 8'h08;
   localparam logic [7:0] TAG_SDX = 8'h0B;
   localparam logic [7:0] TAG_RSV = 8'h0C;
   localparam logic [7:0] TAG_SQU = 8'h0E;
   localparam logic [7:0] TAG_SCU = 8'h0F;
   localparam logic [7:0] TAG_SC0 = 8'h10;
   localparam logic [7:0] TAG_SC7 = 8'h17;
   localparam logic [7:0] TAG_SD0 = 8'h18;
   localparam logic [7:0] TAG_SD7 = 8'h1F;
   // unicode mode tags
   localparam logic [7:0] TAG_UC0 = 8'hE0;
   localparam logic [7:0] TAG_UC7 = 8'hE7;
   localparam logic [7:0] TAG_UD0 = 8'hE8;
   localparam logic [7:0] TAG_UD7 = 8'hEF;
   localparam logic [7:0] TAG_UQU = 8'hF0;
   localparam logic [7:0] TAG_UDX = 8'hF1;
   localparam logic [7:0] TAG_URS = 8'hF2;

   localparam base_type ACTIVE_RESET = 21'h00080;
   localparam base_type SUPP_BASE    = 21'h10000;
   localparam base_type HANGUL_GAP   = 21'h0AC00;

   localparam win_arr_type DYN_DEFAULT = {
      21'h0FF00, 21'h030A0, 21'h03040, 21'h00900,
      21'h00600, 21'h00400, 21'h000C0, 21'h00080
   };

   typedef struct packed {
      logic      umode;
      base_type  active;
      phase_type phase;
      logic [7:0] held;
      logic [2:0] pwin;
      logic      halted;
   } state_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic [1:0]  status;
      logic        run_last;
   } res_type;

   typedef struct packed {
      state_type  nx;
      logic [1:0] count;
      logic       win_we;
      logic [2:0] win_idx;
      base_type   win_base;
      res_type    res0;
      logic [15:0] low_unit;
   } dec_type;

   typedef struct packed {
      logic     ok;
      base_type base;
   } offset_type;

   function automatic base_type static_win(input logic [2:0] idx);
      base_type r;
      case (idx)
         3'd0:    r = 21'h00000;
         3'd1:    r = 21'h00080;
         3'd2:    r = 21'h00100;
         3'd3:    r = 21'h00300;
         3'd4:    r = 21'h02000;
         3'd5:    r = 21'h02080;
         3'd6:    r = 21'h02100;
         default: r = 21'h03000;
      endcase
      return r;
   endfunction

   function automatic base_type special_win(input logic [2:0] idx);
      base_type r;
      case (idx)
         3'd0:    r = 21'h000C0;
         3'd1:    r = 21'h00250;
         3'd2:    r = 21'h00370;
         3'd3:    r = 21'h00530;
         3'd4:    r = 21'h03040;
         3'd5:    r = 21'h030A0;
         default: r = 21'h0FF60;
      endcase
      return r;
   endfunction

   // window offset byte of SDn/UDn to a base; zero and A8..F8 are reserved
   function automatic offset_type offset_base(input logic [7:0] b);
      offset_type r;
      logic [7:0] sidx;
      sidx = b - 8'hF9;
      r.ok = 1'b1;
      r.base = BASE_W'({b, 7'd0});
      if (b >= 8'hF9) begin
         r.base = special_win(sidx[2:0]);
      end else if (b >= 8'h01 && b <= 8'h67) begin
         r.base = BASE_W'({b, 7'd0});
      end else if (b >= 8'h68 && b <= 8'hA7) begin
         r.base = BASE_W'({b, 7'd0}) + HANGUL_GAP;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/scsu_req_if.sv
// Request channel: one compressed byte per transfer with its buffer-end mark.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface scsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       buffer_end;

   modport source (output valid, output in_byte, output buffer_end, input ready);
   modport sink   (input valid, input in_byte, input buffer_end, output ready);
endinterface

`default_nettype wire

// File: rtl/core/scsu_rsp_if.sv
// Response channel: one UTF-16 code unit or status per transfer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface scsu_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic [1:0]  status;
   logic        run_last;

   modport source (output valid, output code_unit, output status, output run_last,
                   input ready);
   modport sink   (input valid, input code_unit, input status, input run_last,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/core/scsu_decode.sv
// Combinational decode of one SCSU byte against the current decoder state.
// Depends on scsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scsu_decode
   import scsu_pkg::*;
(
   input  state_type   st,
   input  win_arr_type win,
   input  logic [7:0]  b,
   input  logic        buf_end,
   output dec_type     dec
);

   logic [2:0]  rd_idx;
   base_type    rd_base;
   offset_type  ob;
   base_type    cp;
   base_type    supp;
   base_type    dx_base;
   logic        emit;
   logic        err;
   state_type   nx;

   assign rd_idx  = (st.phase == PH_SQN) ? st.pwin : b[2:0];
   assign rd_base = win[rd_idx];
   assign ob      = offset_base(b);
   assign dx_base = SUPP_BASE + BASE_W'({st.held[4:0], b, 7'd0});
   assign supp    = cp - SUPP_BASE;

   always_comb begin
      nx = st;
      emit = 1'b0;
      err = 1'b0;
      cp = '0;
      dec.win_we = 1'b0;
      dec.win_idx = st.pwin;
      dec.win_base = ob.base;
      if (!st.halted) begin
         nx.phase = PH_NONE;
         case (st.phase)
            PH_SQN: begin
               emit = 1'b1;
               if (!b[7]) begin
                  cp = static_win(st.pwin) + BASE_W'(b);
               end else begin
                  cp = rd_base + BASE_W'(b[6:0]);
               end
            end
            PH_QHI: begin
               nx.held = b;
               nx.phase = PH_QLO;
            end
            PH_QLO: begin
               emit = 1'b1;
               cp = BASE_W'({st.held, b});
            end
            PH_DOFF: begin
               if (ob.ok) begin
                  nx.umode = 1'b0;
                  nx.active = ob.base;
                  dec.win_we = 1'b1;
               end else begin
                  err = 1'b1;
               end
            end
            PH_DXHI: begin
               nx.held = b;
               nx.phase = PH_DXLO;
            end
            PH_DXLO: begin
               nx.umode = 1'b0;
               nx.active = dx_base;
               dec.win_we = 1'b1;
               dec.win_idx = st.held[7:5];
               dec.win_base = dx_base;
            end
            default: begin
               if (st.umode) begin
                  if (b < TAG_UC0 || b > TAG_URS) begin
                     nx.held = b;
                     nx.phase = PH_QLO;
                  end else if (b == TAG_UQU) begin
                     nx.phase = PH_QHI;
                  end else if (b <= TAG_UC7) begin
                     nx.active = rd_base;
                     nx.umode = 1'b0;
                  end else if (b <= TAG_UD7) begin
                     nx.pwin = b[2:0];
                     nx.phase = PH_DOFF;
                  end else if (b == TAG_UDX) begin
                     nx.phase = PH_DXHI;
                  end else begin
                     err = 1'b1;
                  end
               end else begin
                  if (b == 8'h00 || b == 8'h09 || b == 8'h0A || b == 8'h0D ||
                      (b >= 8'h20 && b <= 8'h7F)) begin
                     emit = 1'b1;
                     cp = BASE_W'(b);
                  end else if (b[7]) begin
                     emit = 1'b1;
                     cp = st.active + BASE_W'(b[6:0]);
                  end else if (b >= TAG_SQ0 && b <= TAG_SQ7) begin
                     nx.pwin = 3'(b - TAG_SQ0);
                     nx.phase = PH_SQN;
                  end else if (b == TAG_SDX) begin
                     nx.phase = PH_DXHI;
                  end else if (b == TAG_SQU) begin
                     nx.phase = PH_QHI;
                  end else if (b == TAG_SCU) begin
                     nx.umode = 1'b1;
                  end else if (b >= TAG_SC0 && b <= TAG_SC7) begin
                     nx.active = rd_base;
                  end else if (b >= TAG_SD0 && b <= TAG_SD7) begin
                     nx.pwin = b[2:0];
                     nx.phase = PH_DOFF;
                  end else begin
                     // only the reserved tag is left here
                     err = 1'b1;
                  end
               end
            end
         endcase
         if (err) begin
            nx.halted = 1'b1;
            nx.phase = PH_NONE;
         end
      end

      dec.count = 2'd0;
      dec.res0 = '{code_unit: cp[15:0], status: ST_UNIT, run_last: 1'b1};
      dec.low_unit = 16'hDC00 | 16'(supp[9:0]);
      if (emit) begin
         if (cp[20:16] != 5'd0) begin
            dec.count = 2'd2;
            dec.res0.code_unit = 16'hD800 + 16'(supp[19:10]);
            dec.res0.run_last = 1'b0;
         end else begin
            dec.count = 2'd1;
         end
      end
      if (err) begin
         dec.count = 2'd1;
         dec.res0 = '{code_unit: 16'h0000, status: ST_ERR, run_last: 1'b1};
      end
      if (buf_end) begin
         if (nx.phase != PH_NONE) begin
            dec.count = 2'd1;
            dec.res0 = '{code_unit: 16'h0000, status: ST_TRUNC, run_last: 1'b1};
         end
         nx.umode = 1'b0;
         nx.phase = PH_NONE;
         nx.halted = 1'b0;
      end
      dec.nx = nx;
   end

endmodule

`default_nettype wire

// File: rtl/core/scsu_unicode_decompressor.sv
// SCSU to UTF-16 decoder, top level.
// Depends on scsu_pkg, scsu_req_if, scsu_rsp_if and scsu_decode.
//
// Use: bytes of the compressed stream arrive on the req channel, one per
// request, with buffer_end set on the last byte of a buffer. Each byte
// produces zero, one or two responses on rsp: a code unit (status 0), an
// error for a reserved byte (status 1, decoding halts until buffer end) or a
// truncation mark for a tag left open at buffer end (status 2). run_last is
// set on the last response of a byte.
// An accepted byte is held in the input register and decoded from there;
// its first response is then registered in the output register.
// Throughput: one byte per cycle while the receiver does not stall; the limit
// is the single output register, which presents one code unit per cycle, so a
// byte yielding a surrogate pair holds it for both of its units in turn.
// Reset restores single-byte mode, the default dynamic windows and the
// default active window, and drops anything in flight.
// When the receiver stalls, the output register holds; bytes that yield no
// response still pass, the first one that yields a response waits in the
// input register and req_ready falls.

`timescale 1ns / 1ps
`default_nettype none

module scsu_unicode_decompressor
   import scsu_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   scsu_req_if.sink    req,
   scsu_rsp_if.source  rsp
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic        in_end_ff, in_end_in;
   state_type   state_ff, state_in;
   win_arr_type win_ff, win_in;
   res_type     slot_ff, slot_in;
   logic        slot_valid_ff, slot_valid_in;
   logic [15:0] low_ff, low_in;
   logic        low_valid_ff, low_valid_in;

   dec_type     dec;
   logic        out_free;
   logic        commit;
   logic        req_take;
   logic        rsp_take;

   scsu_decode u_decode (
      .st      (state_ff),
      .win     (win_ff),
      .b       (in_byte_ff),
      .buf_end (in_end_ff),
      .dec     (dec)
   );

   assign rsp_take  = slot_valid_ff && rsp.ready;
   assign out_free  = !slot_valid_ff || (rsp.ready && !low_valid_ff);
   assign commit    = in_valid_ff && ((dec.count == 2'd0) || out_free);
   assign req.ready = !in_valid_ff || commit;
   assign req_take  = req.valid && req.ready;

   assign rsp.valid     = slot_valid_ff;
   assign rsp.code_unit = slot_ff.code_unit;
   assign rsp.status    = slot_ff.status;
   assign rsp.run_last  = slot_ff.run_last;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_end_in   = in_end_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req.in_byte;
         in_end_in   = req.buffer_end;
      end else if (commit) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      win_in   = win_ff;
      if (commit) begin
         state_in = dec.nx;
         if (dec.win_we) begin
            win_in[dec.win_idx] = dec.win_base;
         end
      end
   end

   always_comb begin
      slot_in       = slot_ff;
      slot_valid_in = slot_valid_ff;
      low_in        = low_ff;
      low_valid_in  = low_valid_ff;
      if (commit && dec.count != 2'd0) begin
         slot_in       = dec.res0;
         slot_valid_in = 1'b1;
         low_in        = dec.low_unit;
         low_valid_in  = (dec.count == 2'd2);
      end else if (rsp_take) begin
         if (low_valid_ff) begin
            slot_in      = '{code_unit: low_ff, status: ST_UNIT, run_last: 1'b1};
            low_valid_in = 1'b0;
         end else begin
            slot_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         slot_valid_ff <= 1'b0;
         low_valid_ff  <= 1'b0;
         state_ff      <= '{umode: 1'b0, active: ACTIVE_RESET, phase: PH_NONE,
                            held: 8'h00, pwin: 3'd0, halted: 1'b0};
         win_ff        <= DYN_DEFAULT;
      end else begin
         in_valid_ff   <= in_valid_in;
         slot_valid_ff <= slot_valid_in;
         low_valid_ff  <= low_valid_in;
         state_ff      <= state_in;
         win_ff        <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_end_ff  <= in_end_in;
      slot_ff    <= slot_in;
      low_ff     <= low_in;
   end

`ifndef SYNTHESIS
   // the low surrogate only waits behind a presented high surrogate
   a_low_behind_slot: assert property (@(posedge clock) disable iff (reset)
      low_valid_ff |-> slot_valid_ff)
      else $error("low surrogate pending with empty output slot");

   a_low_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && low_valid_ff) |=>
         (slot_valid_ff && slot_ff.code_unit[15:10] == 6'b110111 && slot_ff.run_last))
      else $error("second unit of a pair is not a low surrogate");

   a_halt_no_tag: assert property (@(posedge clock) disable iff (reset)
      state_ff.halted |-> (state_ff.phase == PH_NONE))
      else $error("tag pending while halted");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (slot_valid_ff && !rsp.ready) |=> (slot_valid_ff && $stable(slot_ff)))
      else $error("output slot changed while stalled");
`endif

endmodule

`default_nettype wire
